/* sv/bfb_pkg.sv */
// Package: types, constants and helpers for the Bloom filter builder.
`default_nettype none
package bfb_pkg;

  localparam int unsigned KEY_W        = 64;
  localparam int unsigned MAX_KEYS     = 1024;
  localparam int unsigned KIDX_W       = 10;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned MAX_BPK      = 32;
  localparam int unsigned FBYTES       = 4096;
  localparam int unsigned FADDR_W      = 12;
  localparam int unsigned NBITS_W      = 16;
  localparam int unsigned PROBE_W      = 5;
  localparam int unsigned BPK_W        = 6;
  localparam logic [BPK_W-1:0] BPK_RESET = 6'd10;
  localparam logic [KEY_W-1:0] PROBE_STEP = 64'h0000_0000_9e37_79b9;
  localparam logic [PROBE_W-1:0] PROBE_LIMIT = 5'd30;

  // request codes
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_FINISH = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  // status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FINISHED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD      = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CLR,
    S_MODC,
    S_MODS,
    S_KRD,
    S_KLD,
    S_MODK,
    S_PRD,
    S_PWR
  } state_t;

  // clamp the register to 1..MAX_BPK
  function automatic logic [BPK_W-1:0] eff_bpk(input logic [BPK_W-1:0] b);
    logic [BPK_W-1:0] v;
    v = b;
    if (b == '0) v = BPK_W'(1);
    else if (b > BPK_W'(MAX_BPK)) v = BPK_W'(MAX_BPK);
    return v;
  endfunction

  // floor(693*b/1000) by reciprocal 1049/2^20 (exact for b <= 32), clamped 1..30
  function automatic logic [PROBE_W-1:0] probes_for(input logic [BPK_W-1:0] b);
    logic [15:0] x;
    logic [26:0] y;
    logic [PROBE_W-1:0] p;
    x = 16'd693 * 16'(b);
    y = 27'(x) * 27'd1049;
    p = PROBE_W'(y >> 20);
    if (p == '0) p = PROBE_W'(1);
    if (p > PROBE_LIMIT) p = PROBE_LIMIT;
    return p;
  endfunction

endpackage
`default_nettype wire

/* sv/bfb_if.sv */
// Channel interfaces: request, result and configuration.
`default_nettype none
interface bfb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] key;
  logic [11:0] byte_address;
  modport source (output valid, req_type, key, byte_address, input ready);
  modport sink   (input valid, req_type, key, byte_address, output ready);
endinterface

interface bfb_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] entry_total;
  logic [10:0] unique_total;
  logic [63:0] smallest_key;
  logic [63:0] largest_key;
  logic [15:0] filter_bits;
  logic [4:0]  probe_count;
  logic [7:0]  read_byte;
  modport source (output valid, status, entry_total, unique_total, smallest_key,
                  largest_key, filter_bits, probe_count, read_byte, input ready);
  modport sink   (input valid, status, entry_total, unique_total, smallest_key,
                  largest_key, filter_bits, probe_count, read_byte, output ready);
endinterface

interface bfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* sv/bloom_filter_builder_top.sv */
// Bloom filter builder: key intake, filter build sequencer and byte readout.
//
// Add and failed requests return one word, registered in the cycle after they
// are taken. A good read passes through the filter memory read register and
// S_RD before its result is registered. Finish clears the first ceil(n*bpk/8)
// filter bytes one per cycle, then runs two serial remainders (2^64 mod bits
// and the probe step mod bits), then for each stored key one key memory read
// (S_KRD, S_KLD), a serial remainder of the key, and a filter byte
// read-modify-write (S_PRD, S_PWR) per probe. One request is in work at a time;
// a new one is taken as soon as the previous result is taken.
`default_nettype none
module bloom_filter_builder_top (
  input  wire logic clk,
  input  wire logic rst_n,
  bfb_req_if.sink   in_ch,
  bfb_res_if.source out_ch,
  bfb_cfg_if.sink   cfg_ch
);
  import bfb_pkg::*;

  // memories
  logic [KEY_W-1:0] key_mem [MAX_KEYS];
  logic [7:0]       flt_mem [FBYTES];
  logic [KEY_W-1:0] kr_q;
  logic [7:0]       fr_q;

  // control and state registers
  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [7:0]          rbyte_r, rbyte_nxt;
  logic [31:0]         entry_r, entry_nxt;
  logic [CNT_W-1:0]    stored_r, stored_nxt;
  logic [KEY_W-1:0]    min_r, min_nxt, max_r, max_nxt, last_r, last_nxt;
  logic [NBITS_W-1:0]  built_r, built_nxt;
  logic [PROBE_W-1:0]  bprobe_r, bprobe_nxt;
  logic                done_r, done_nxt;
  logic [BPK_W-1:0]    bpk_r, bpk_nxt;
  logic [NBITS_W-1:0]  nbits_r, nbits_nxt;
  logic [PROBE_W-1:0]  nprobe_r, nprobe_nxt, pidx_r, pidx_nxt;
  logic [FADDR_W-1:0]  clr_r, clr_nxt, clr_last_r, clr_last_nxt;
  logic [KIDX_W-1:0]   kidx_r, kidx_nxt;
  logic [KEY_W:0]      md_r, md_nxt;
  logic [NBITS_W-1:0]  rem_r, rem_nxt, c_r, c_nxt, s_r, s_nxt, r_r, r_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic [KEY_W-1:0]    h_r, h_nxt;

  // memory port controls
  logic               kw_en;
  logic [FADDR_W-1:0] fr_addr, fw_addr;
  logic               fw_en;
  logic [7:0]         fw_data;

  // helpers
  logic               out_free, in_acc, need_slot;
  logic [BPK_W-1:0]   bpk_e;
  logic [16:0]        prod;
  logic [13:0]        nbytes;
  logic [NBITS_W-1:0] t_mod, r_sum, r_adj;
  logic [KEY_W-1:0]   h_add;
  logic               h_carry;

  assign out_free      = !out_valid_r || out_ch.ready;
  assign in_ch.ready   = (state_r == S_IDLE) && out_free;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.entry_total  = entry_r;
  assign out_ch.unique_total = stored_r;
  assign out_ch.smallest_key = min_r;
  assign out_ch.largest_key  = max_r;
  assign out_ch.filter_bits  = built_r;
  assign out_ch.probe_count  = bprobe_r;
  assign out_ch.read_byte    = rbyte_r;

  assign need_slot = (stored_r == '0) || (last_r != in_ch.key);
  assign bpk_e     = eff_bpk(bpk_r);
  assign prod      = 17'(stored_r) * 17'(bpk_e);
  assign nbytes    = 14'((prod + 17'd7) >> 3);

  // one step of the serial remainder
  always_comb begin
    t_mod = {rem_r[NBITS_W-2:0], md_r[KEY_W]};
    if (t_mod >= nbits_r) t_mod = t_mod - nbits_r;
  end

  // next probe position: (r + s - carry*(2^64 mod n)) mod n
  always_comb begin
    h_add   = h_r + PROBE_STEP;
    h_carry = h_add < h_r;
    r_sum   = NBITS_W'(17'(r_r) + 17'(s_r) >= 17'(nbits_r) ?
              17'(r_r) + 17'(s_r) - 17'(nbits_r) : 17'(r_r) + 17'(s_r));
    r_adj   = r_sum;
    if (h_carry) r_adj = (r_sum >= c_r) ? r_sum - c_r : r_sum + nbits_r - c_r;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    rbyte_nxt     = rbyte_r;
    entry_nxt     = entry_r;
    stored_nxt    = stored_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    last_nxt      = last_r;
    built_nxt     = built_r;
    bprobe_nxt    = bprobe_r;
    done_nxt      = done_r;
    bpk_nxt       = cfg_ch.valid ? cfg_ch.data : bpk_r;
    nbits_nxt     = nbits_r;
    nprobe_nxt    = nprobe_r;
    pidx_nxt      = pidx_r;
    clr_nxt       = clr_r;
    clr_last_nxt  = clr_last_r;
    kidx_nxt      = kidx_r;
    md_nxt        = md_r;
    rem_nxt       = rem_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    h_nxt         = h_r;
    kw_en         = 1'b0;
    fr_addr       = in_ch.byte_address;
    fw_en         = 1'b0;
    fw_addr       = clr_r;
    fw_data       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rbyte_nxt = '0;
          case (in_ch.req_type)
            REQ_ADD: begin
              out_valid_nxt = 1'b1;
              if (done_r) status_nxt = ST_FINISHED;
              else if (need_slot && stored_r >= CNT_W'(MAX_KEYS)) status_nxt = ST_FULL;
              else begin
                status_nxt = ST_OK;
                if (need_slot) begin
                  kw_en      = 1'b1;
                  stored_nxt = stored_r + CNT_W'(1);
                  last_nxt   = in_ch.key;
                end
                if (entry_r != '1) entry_nxt = entry_r + 32'd1;
                if (in_ch.key < min_r) min_nxt = in_ch.key;
                if (in_ch.key > max_r) max_nxt = in_ch.key;
              end
            end
            REQ_FINISH: begin
              if (done_r) begin
                status_nxt    = ST_FINISHED;
                out_valid_nxt = 1'b1;
              end else if (entry_r == '0 || stored_r == '0) begin
                status_nxt    = ST_EMPTY;
                out_valid_nxt = 1'b1;
              end else begin
                nbits_nxt    = NBITS_W'({nbytes, 3'b000});
                nprobe_nxt   = probes_for(bpk_e);
                clr_nxt      = '0;
                clr_last_nxt = FADDR_W'(nbytes - 14'd1);
                state_nxt    = S_CLR;
              end
            end
            REQ_READ: begin
              if (!done_r || 13'(in_ch.byte_address) >= 13'(built_r >> 3)) begin
                status_nxt    = ST_BAD;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
              status_nxt    = ST_BAD;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        status_nxt    = ST_OK;
        rbyte_nxt     = fr_q;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CLR: begin
        fw_en   = 1'b1;
        fw_addr = clr_r;
        clr_nxt = clr_r + FADDR_W'(1);
        if (clr_r == clr_last_r) begin
          md_nxt    = {1'b1, {KEY_W{1'b0}}};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_MODC;
        end
      end
      S_MODC: begin
        rem_nxt = t_mod;
        md_nxt  = {md_r[KEY_W-1:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(KEY_W)) begin
          c_nxt     = t_mod;
          md_nxt    = {1'b0, PROBE_STEP};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_MODS;
        end
      end
      S_MODS: begin
        rem_nxt = t_mod;
        md_nxt  = {md_r[KEY_W-1:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(KEY_W)) begin
          s_nxt     = t_mod;
          kidx_nxt  = '0;
          state_nxt = S_KRD;
        end
      end
      S_KRD: begin
        state_nxt = S_KLD;
      end
      S_KLD: begin
        md_nxt    = {1'b0, kr_q};
        h_nxt     = kr_q;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_MODK;
      end
      S_MODK: begin
        rem_nxt = t_mod;
        md_nxt  = {md_r[KEY_W-1:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(KEY_W)) begin
          r_nxt     = t_mod;
          pidx_nxt  = '0;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        fr_addr   = r_r[NBITS_W-2:3];
        state_nxt = S_PWR;
      end
      S_PWR: begin
        fw_en    = 1'b1;
        fw_addr  = r_r[NBITS_W-2:3];
        fw_data  = fr_q | (8'd1 << r_r[2:0]);
        r_nxt    = r_adj;
        h_nxt    = h_add;
        pidx_nxt = pidx_r + PROBE_W'(1);
        state_nxt = S_PRD;
        if (pidx_r == nprobe_r - PROBE_W'(1)) begin
          kidx_nxt  = kidx_r + KIDX_W'(1);
          state_nxt = S_KRD;
          if (CNT_W'(kidx_r) == stored_r - CNT_W'(1)) begin
            built_nxt     = nbits_r;
            bprobe_nxt    = nprobe_r;
            done_nxt      = 1'b1;
            status_nxt    = ST_OK;
            rbyte_nxt     = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // key store
  always_ff @(posedge clk) begin
    if (kw_en) key_mem[stored_r[KIDX_W-1:0]] <= in_ch.key;
    kr_q <= key_mem[kidx_r];
  end

  // filter store
  always_ff @(posedge clk) begin
    if (fw_en) flt_mem[fw_addr] <= fw_data;
    fr_q <= flt_mem[fr_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      entry_r     <= '0;
      stored_r    <= '0;
      min_r       <= '1;
      max_r       <= '0;
      built_r     <= '0;
      bprobe_r    <= '0;
      done_r      <= 1'b0;
      bpk_r       <= BPK_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      entry_r     <= entry_nxt;
      stored_r    <= stored_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      built_r     <= built_nxt;
      bprobe_r    <= bprobe_nxt;
      done_r      <= done_nxt;
      bpk_r       <= bpk_nxt;
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    rbyte_r    <= rbyte_nxt;
    last_r     <= last_nxt;
    nbits_r    <= nbits_nxt;
    nprobe_r   <= nprobe_nxt;
    pidx_r     <= pidx_nxt;
    clr_r      <= clr_nxt;
    clr_last_r <= clr_last_nxt;
    kidx_r     <= kidx_nxt;
    md_r       <= md_nxt;
    rem_r      <= rem_nxt;
    c_r        <= c_nxt;
    s_r        <= s_nxt;
    r_r        <= r_nxt;
    cnt_r      <= cnt_nxt;
    h_r        <= h_nxt;
  end

endmodule
`default_nettype wire

/* test/tb.sv */
// Testbench for the Bloom filter builder: directed and random requests, scored by a predictor.
`timescale 1ns / 1ps
module tb;
  import bfb_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 500000;

  // one request word and one result word
  typedef struct {
    logic [1:0]  req;
    logic [63:0] key;
    logic [11:0] addr;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] entry_total;
    logic [10:0] unique_total;
    logic [63:0] smallest_key;
    logic [63:0] largest_key;
    logic [15:0] filter_bits;
    logic [4:0]  probe_count;
    logic [7:0]  read_byte;
  } result_t;

  logic clk;
  logic rst_n;

  bfb_req_if in_ch();
  bfb_res_if out_ch();
  bfb_cfg_if cfg_ch();

  bloom_filter_builder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // shadow state of the builder
  logic [63:0] key_mem [MAX_KEYS];
  logic [7:0]  filter_mem [FBYTES];
  int unsigned kept_keys;
  logic [31:0] entries;
  logic [63:0] min_key;
  logic [63:0] max_key;
  logic [15:0] built_nbits;
  logic [4:0]  built_probes;
  logic        built;
  logic [5:0]  bpk_reg;

  request_t pending_requests[$];
  result_t  expected_results[$];
  int unsigned errors;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          word_sent;

  // build the filter from the kept keys
  function automatic void build_filter();
    logic [5:0]  bpk;
    logic [31:0] nbits;
    logic [31:0] raw_probes;
    logic [63:0] h;
    logic [31:0] bit_idx;
    bpk = bpk_reg;
    if (bpk == 0) bpk = 1;
    else if (bpk > MAX_BPK) bpk = MAX_BPK;
    nbits = ((kept_keys * bpk + 7) / 8) * 8;
    raw_probes = (693 * bpk) / 1000;
    if (raw_probes < 1) raw_probes = 1;
    if (raw_probes > 30) raw_probes = 30;
    for (int b = 0; b < FBYTES; b++) filter_mem[b] = 8'h00;
    for (int k = 0; k < kept_keys; k++) begin
      for (int i = 0; i < raw_probes; i++) begin
        h = key_mem[k] + 64'(i) * 64'h9e3779b9;
        bit_idx = 32'(h % 64'(nbits));
        if ((bit_idx >> 3) < FBYTES) filter_mem[bit_idx >> 3][bit_idx[2:0]] = 1'b1;
      end
    end
    built_nbits = nbits[15:0];
    built_probes = raw_probes[4:0];
    built = 1'b1;
  endfunction

  // expected result of one accepted request, updating the shadow state
  function automatic result_t predict_result(request_t r);
    result_t res;
    bit need_slot;
    res.read_byte = 8'h00;
    res.status = ST_OK;
    case (r.req)
      REQ_ADD: begin
        need_slot = (kept_keys == 0) || (key_mem[kept_keys-1] != r.key);
        if (built) res.status = ST_FINISHED;
        else if (need_slot && kept_keys >= MAX_KEYS) res.status = ST_FULL;
        else begin
          if (need_slot) begin
            key_mem[kept_keys] = r.key;
            kept_keys++;
          end
          if (entries != 32'hFFFF_FFFF) entries++;
          if (r.key < min_key) min_key = r.key;
          if (r.key > max_key) max_key = r.key;
        end
      end
      REQ_FINISH: begin
        if (built) res.status = ST_FINISHED;
        else if (entries == 0 || kept_keys == 0) res.status = ST_EMPTY;
        else build_filter();
      end
      REQ_READ: begin
        if (!built || r.addr >= (built_nbits >> 3)) res.status = ST_BAD;
        else res.read_byte = filter_mem[r.addr];
      end
      default: res.status = ST_BAD;
    endcase
    res.entry_total = entries;
    res.unique_total = kept_keys[10:0];
    res.smallest_key = min_key;
    res.largest_key = max_key;
    res.filter_bits = built_nbits;
    res.probe_count = built_probes;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // scoreboard side: predict on request accept, compare on result accept
  always @(posedge clk) begin
    request_t r;
    result_t e;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      r.req = in_ch.req_type;
      r.key = in_ch.key;
      r.addr = in_ch.byte_address;
      expected_results = {expected_results, predict_result(r)};
      void'(pending_requests.pop_front());
      word_sent = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("status", 64'(e.status), 64'(out_ch.status));
        check_field("entry_total", 64'(e.entry_total), 64'(out_ch.entry_total));
        check_field("unique_total", 64'(e.unique_total), 64'(out_ch.unique_total));
        check_field("smallest_key", e.smallest_key, out_ch.smallest_key);
        check_field("largest_key", e.largest_key, out_ch.largest_key);
        check_field("filter_bits", 64'(e.filter_bits), 64'(out_ch.filter_bits));
        check_field("probe_count", 64'(e.probe_count), 64'(out_ch.probe_count));
        check_field("read_byte", 64'(e.read_byte), 64'(out_ch.read_byte));
      end
    end
  end

  // request driver and result-side ready, both on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || word_sent) begin
        word_sent = 1'b0;
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.req_type <= pending_requests[0].req;
          in_ch.key <= pending_requests[0].key;
          in_ch.byte_address <= pending_requests[0].addr;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus-side shadow, used only to steer key generation toward a full store
  int unsigned gen_kept;
  logic [63:0] gen_last;

  function automatic void queue_request(logic [1:0] req, logic [63:0] key, logic [11:0] addr);
    request_t r;
    r.req = req;
    r.key = key;
    r.addr = addr;
    if (req == REQ_ADD && (gen_kept == 0 || gen_last != key) && gen_kept < MAX_KEYS) begin
      gen_kept++;
      gen_last = key;
    end
    pending_requests = {pending_requests, r};
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic wait_idle();
    while (pending_requests.size() != 0 || expected_results.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bpk(logic [5:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    bpk_reg = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned n;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_ADD;
    in_ch.key = '0;
    in_ch.byte_address = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    word_sent = 1'b0;
    errors = 0;
    kept_keys = 0;
    entries = 0;
    min_key = '1;
    max_key = '0;
    built_nbits = 0;
    built_probes = 0;
    built = 1'b0;
    bpk_reg = BPK_RESET;
    gen_kept = 0;
    gen_last = '0;
    send_idle_pct = 18;
    recv_idle_pct = 65;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: requests before any key, extremes of the key, duplicates
    write_bpk(6'd0);
    queue_request(REQ_READ, '0, 12'd0);
    queue_request(REQ_FINISH, '0, '0);
    queue_request(REQ_UNKNOWN, '1, 12'hFFF);
    queue_request(REQ_READ, '1, 12'hFFF);
    queue_request(REQ_ADD, '1, '0);
    queue_request(REQ_ADD, '1, '0);
    queue_request(REQ_ADD, '0, '0);
    queue_request(REQ_ADD, '0, '0);
    queue_request(REQ_ADD, 64'd1, '0);
    queue_request(REQ_ADD, 64'h8000_0000_0000_0000, '0);
    queue_request(REQ_ADD, 64'h5555_5555_5555_5555, '0);
    queue_request(REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    queue_request(REQ_READ, '0, 12'd5);
    queue_request(REQ_UNKNOWN, '0, '0);
    wait_idle();

    // random keys with runs of repeats, sender lightly idle, receiver mostly stalled
    write_bpk(6'd32);
    for (int i = 0; i < 700; i++) begin
      n = $urandom_range(99);
      if (n < 25) queue_request(REQ_ADD, gen_last, 12'($urandom));
      else if (n < 28) queue_request(REQ_READ, rand_key(), 12'($urandom));
      else if (n < 30) queue_request(REQ_UNKNOWN, rand_key(), 12'($urandom));
      else queue_request(REQ_ADD, rand_key(), 12'($urandom));
    end
    wait_idle();

    // fill the key store, overflow it, then build at the clamped maximum
    write_bpk(6'd63);
    send_idle_pct = 65;
    recv_idle_pct = 18;
    while (gen_kept < MAX_KEYS) begin
      if ($urandom_range(99) < 20) queue_request(REQ_ADD, gen_last, '0);
      else queue_request(REQ_ADD, rand_key(), '0);
    end
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(1) == 0) queue_request(REQ_ADD, gen_last, '0);
      else queue_request(REQ_ADD, rand_key(), '0);
    end
    queue_request(REQ_FINISH, '0, '0);
    queue_request(REQ_FINISH, '0, '0);
    queue_request(REQ_ADD, rand_key(), '0);
    wait_idle();

    // reads of the built filter; a register write now must change nothing
    write_bpk(6'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_request(REQ_READ, '0, 12'd0);
    queue_request(REQ_READ, '0, 12'hFFF);
    for (int i = 0; i < 750; i++) begin
      n = $urandom_range(99);
      if (n < 3) queue_request(REQ_ADD, rand_key(), 12'($urandom));
      else if (n < 5) queue_request(REQ_FINISH, rand_key(), 12'($urandom));
      else if (n < 7) queue_request(REQ_UNKNOWN, rand_key(), 12'($urandom));
      else queue_request(REQ_READ, rand_key(), 12'($urandom));
    end
    wait_idle();
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
